// ===== sv/hmpf_pkg.sv =====
package hmpf_pkg;

	localparam int SAMPLES_DEF = 9;
	localparam int CM_W = 10;
	localparam int FRONT_W = 12;
	localparam int COORD_W = 12;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 10;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_HEADING = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ARENA_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ARENA_WIDTH = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE = 2'd3;

	// Headings in quarter turns.
	localparam logic [1:0] HDG_0 = 2'd0;
	localparam logic [1:0] HDG_1 = 2'd1;
	localparam logic [1:0] HDG_2 = 2'd2;
	localparam logic [1:0] HDG_3 = 2'd3;

	localparam logic [CM_W-1:0] ARENA_LENGTH_RST = 10'd247;
	localparam logic [CM_W-1:0] ARENA_WIDTH_RST = 10'd267;
	localparam logic [CM_W-1:0] MAX_RANGE_RST = 10'd450;

	// Wall distance minus 12.5 cm, truncated toward zero.
	localparam logic signed [FRONT_W-1:0] WALL_MARGIN_HI = 12'sd13;
	localparam logic signed [FRONT_W-1:0] WALL_MARGIN_LO = 12'sd12;
	localparam logic signed [FRONT_W-1:0] FRONT_OFFSET = 12'sd12;
	localparam logic [COORD_W-1:0] SIDE_OFFSET = 12'd9;
	localparam logic [COORD_W-1:0] SIDE_OFFSET_HDG_2 = 12'd8;

	typedef struct packed {
		logic [CM_W-1:0] front_left_cm;
		logic [CM_W-1:0] front_right_cm;
		logic [CM_W-1:0] left_cm;
		logic [CM_W-1:0] right_cm;
	} sample_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} position_t;

	typedef struct packed {
		logic [1:0] heading;
		logic [CM_W-1:0] arena_length;
		logic [CM_W-1:0] arena_width;
		logic [CM_W-1:0] max_range;
	} cfg_t;

	typedef struct packed {
		logic signed [FRONT_W-1:0] front_val;
		logic front_keep;
		logic [CM_W-1:0] side_val;
		logic side_keep;
	} entry_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SORT,
		ST_EMIT
	} back_state_t;

endpackage

// ===== sv/hmpf_front.sv =====
module hmpf_front (
	input hmpf_pkg::sample_t sample,
	input hmpf_pkg::cfg_t cfg,
	output hmpf_pkg::entry_t entry
);
	import hmpf_pkg::*;

	logic [CM_W-1:0] near;
	logic [CM_W-1:0] wall;
	logic signed [FRONT_W-1:0] diff;
	logic signed [FRONT_W-1:0] front_val;
	logic [CM_W-1:0] side_val;

	// A tie between the front sensors takes the right one.
	assign near = (sample.front_left_cm < sample.front_right_cm) ?
		sample.front_left_cm : sample.front_right_cm;
	assign wall = (cfg.heading == HDG_0) ? cfg.arena_length : cfg.arena_width;
	assign diff = $signed({2'b00, wall}) - $signed({2'b00, near});

	always_comb begin
		unique case (cfg.heading) inside
			HDG_0, HDG_1: begin
				front_val = (diff >= WALL_MARGIN_HI) ? diff - WALL_MARGIN_HI :
					diff - WALL_MARGIN_LO;
			end
			default: begin
				front_val = $signed({2'b00, near}) + FRONT_OFFSET;
			end
		endcase
		unique case (cfg.heading) inside
			HDG_0, HDG_3: side_val = sample.left_cm;
			default: side_val = sample.right_cm;
		endcase
	end

	assign entry.front_val = front_val;
	assign entry.front_keep = front_val <= $signed({2'b00, cfg.max_range});
	assign entry.side_val = side_val;
	assign entry.side_keep = side_val <= cfg.max_range;

endmodule

// ===== sv/hmpf_queue.sv =====
module hmpf_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hmpf_pkg::entry_t push_entry,
	output logic full,
	input logic pop,
	output hmpf_pkg::entry_t pop_entry,
	output logic empty
);
	import hmpf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== sv/hmpf_back.sv =====
module hmpf_back #(
	parameter int SAMPLES = hmpf_pkg::SAMPLES_DEF
) (
	input logic clk,
	input logic arst_n,
	input hmpf_pkg::cfg_t cfg,
	input hmpf_pkg::entry_t entry,
	input logic empty,
	output logic pop,
	output logic pos_valid,
	input logic pos_stall,
	output hmpf_pkg::position_t pos
);
	import hmpf_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int IDX_W = $clog2(SAMPLES);
	localparam int MID = SAMPLES / 2;

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] front_cnt_q, side_cnt_q, front_cnt_d, side_cnt_d;
	logic [CNT_W-1:0] pass_q;
	logic front_take, side_take;
	logic emit;
	logic last_pass;

	logic signed [FRONT_W-1:0] front_q [SAMPLES];
	logic [CM_W-1:0] side_q [SAMPLES];
	logic signed [FRONT_W-1:0] front_swap [SAMPLES];
	logic [CM_W-1:0] side_swap [SAMPLES];

	logic [COORD_W-1:0] side_pos;
	position_t pos_d;
	logic pos_valid_q;
	position_t pos_q;

	assign pop = (state_q == ST_COLLECT) && !empty;
	assign front_take = pop && entry.front_keep && (front_cnt_q != CNT_W'(SAMPLES));
	assign side_take = pop && entry.side_keep && (side_cnt_q != CNT_W'(SAMPLES));
	assign front_cnt_d = front_cnt_q + CNT_W'(front_take);
	assign side_cnt_d = side_cnt_q + CNT_W'(side_take);
	assign last_pass = (pass_q == CNT_W'(SAMPLES - 1));

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				if (pop && front_cnt_d == CNT_W'(SAMPLES) && side_cnt_d == CNT_W'(SAMPLES))
					state_d = ST_SORT;
			end
			ST_SORT: begin
				if (last_pass) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit = !pos_valid_q || !pos_stall;
				if (emit) state_d = ST_COLLECT;
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			front_cnt_q <= '0;
			side_cnt_q <= '0;
			pass_q <= '0;
			pos_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				front_cnt_q <= '0;
				side_cnt_q <= '0;
			end else begin
				front_cnt_q <= front_cnt_d;
				side_cnt_q <= side_cnt_d;
			end
			if (state_q == ST_SORT) pass_q <= last_pass ? '0 : pass_q + 1'b1;
			if (emit) pos_valid_q <= 1'b1;
			else if (!pos_stall) pos_valid_q <= 1'b0;
		end
	end

	// One odd-even transposition pass per cycle; SAMPLES passes leave both
	// channels in descending order.
	always_comb begin
		front_swap = front_q;
		side_swap = side_q;
		for (int j = 0; j < SAMPLES - 1; j++) begin
			if (((j % 2) == 1) == pass_q[0]) begin
				if (front_q[j] < front_q[j+1]) begin
					front_swap[j] = front_q[j+1];
					front_swap[j+1] = front_q[j];
				end
				if (side_q[j] < side_q[j+1]) begin
					side_swap[j] = side_q[j+1];
					side_swap[j+1] = side_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SORT) begin
			front_q <= front_swap;
			side_q <= side_swap;
		end else begin
			if (front_take) front_q[front_cnt_q[IDX_W-1:0]] <= entry.front_val;
			if (side_take) side_q[side_cnt_q[IDX_W-1:0]] <= entry.side_val;
		end
	end

	always_comb begin
		side_pos = {{(COORD_W - CM_W){1'b0}}, side_q[MID]} +
			((cfg.heading == HDG_2) ? SIDE_OFFSET_HDG_2 : SIDE_OFFSET);
		unique case (cfg.heading) inside
			HDG_0, HDG_2: begin
				pos_d.coord_x = $signed(side_pos);
				pos_d.coord_y = front_q[MID];
			end
			default: begin
				pos_d.coord_x = front_q[MID];
				pos_d.coord_y = $signed(side_pos);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) pos_q <= pos_d;
	end

	assign pos_valid = pos_valid_q;
	assign pos = pos_q;

endmodule

// ===== sv/heading_median_position_filter_unit.sv =====
// Position filter for a robot in a rectangular arena. Each accepted sample item
// carries four range readings; the front reading is mapped by the heading
// register to a wall distance and the side reading is taken as is, and each
// channel keeps values no larger than max_range until it holds SAMPLES of them.
// When both channels are full, one position item is produced with the medians
// as coord_x and coord_y, and collection starts over. Sample items are taken
// one per cycle into a two-entry queue while it has room; the collecting side
// drains one item per cycle, and each completed set is then sorted, one sort
// pass per cycle over the stored samples, before the output load, during which
// the queue absorbs new items until it fills. A result waiting in the output
// register holds back the next result and the collection behind it. Configuration
// writes are always accepted and should be made only while the filter is idle.
module heading_median_position_filter_unit #(
	parameter int SAMPLES = hmpf_pkg::SAMPLES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input hmpf_pkg::sample_t sample,
	output logic pos_valid,
	input logic pos_stall,
	output hmpf_pkg::position_t pos,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [hmpf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [hmpf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hmpf_pkg::*;

	cfg_t cfg_q;
	entry_t push_entry;
	entry_t pop_entry;
	logic q_full, q_empty, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heading <= HDG_0;
			cfg_q.arena_length <= ARENA_LENGTH_RST;
			cfg_q.arena_width <= ARENA_WIDTH_RST;
			cfg_q.max_range <= MAX_RANGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADING: cfg_q.heading <= cfg_data[1:0];
				REG_ARENA_LENGTH: cfg_q.arena_length <= cfg_data[CM_W-1:0];
				REG_ARENA_WIDTH: cfg_q.arena_width <= cfg_data[CM_W-1:0];
				REG_MAX_RANGE: cfg_q.max_range <= cfg_data[CM_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample_stall = q_full;

	hmpf_front u_front (
		.sample(sample),
		.cfg(cfg_q),
		.entry(push_entry)
	);

	hmpf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(sample_valid && !q_full),
		.push_entry(push_entry),
		.full(q_full),
		.pop(q_pop),
		.pop_entry(pop_entry),
		.empty(q_empty)
	);

	hmpf_back #(
		.SAMPLES(SAMPLES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.entry(pop_entry),
		.empty(q_empty),
		.pop(q_pop),
		.pos_valid(pos_valid),
		.pos_stall(pos_stall),
		.pos(pos)
	);

endmodule

// ===== bench/hmpf_tb_pkg.sv =====
`timescale 1ns / 1ps
package hmpf_tb_pkg;
	import hmpf_pkg::*;

	localparam int FILL = SAMPLES_DEF;

	class position_scoreboard;
		logic [1:0] heading;
		int arena_length;
		int arena_width;
		int max_range;
		int front_vals[FILL];
		int side_vals[FILL];
		int front_cnt;
		int side_cnt;
		position_t expected_q[$];
		int errors;

		function new();
			heading = HDG_0;
			arena_length = ARENA_LENGTH_RST;
			arena_width = ARENA_WIDTH_RST;
			max_range = MAX_RANGE_RST;
			front_cnt = 0;
			side_cnt = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HEADING: heading = data[1:0];
				REG_ARENA_LENGTH: arena_length = data;
				REG_ARENA_WIDTH: arena_width = data;
				REG_MAX_RANGE: max_range = data;
				default: ;
			endcase
		endfunction

		// Middle element of the set sorted in descending order.
		function int median(int vals[FILL]);
			int sorted[FILL];
			int v;
			int j;
			sorted = vals;
			for (int i = 1; i < FILL; i++) begin
				v = sorted[i];
				j = i - 1;
				while (j >= 0 && sorted[j] < v) begin
					sorted[j + 1] = sorted[j];
					j--;
				end
				sorted[j + 1] = v;
			end
			return sorted[FILL / 2];
		endfunction

		function void note_sample(sample_t s);
			int near_cm;
			int wall;
			int fval;
			int sval;
			int fm;
			int sm;
			int x;
			int y;
			position_t p;
			near_cm = (s.front_left_cm < s.front_right_cm) ? s.front_left_cm : s.front_right_cm;
			if (heading == HDG_0 || heading == HDG_1) begin
				wall = ((heading == HDG_0) ? arena_length : arena_width) - near_cm;
				// Subtracting 12.5 cm and truncating toward zero.
				if (wall >= int'(WALL_MARGIN_HI))
					fval = wall - int'(WALL_MARGIN_HI);
				else
					fval = wall - int'(WALL_MARGIN_LO);
			end else begin
				fval = near_cm + int'(FRONT_OFFSET);
			end
			sval = (heading == HDG_0 || heading == HDG_3) ? int'(s.left_cm) : int'(s.right_cm);

			if (front_cnt < FILL && fval <= max_range) begin
				front_vals[front_cnt] = fval;
				front_cnt++;
			end
			if (side_cnt < FILL && sval <= max_range) begin
				side_vals[side_cnt] = sval;
				side_cnt++;
			end
			if (front_cnt < FILL || side_cnt < FILL)
				return;

			fm = median(front_vals);
			sm = median(side_vals);
			case (heading)
				HDG_0: begin
					x = sm + int'(SIDE_OFFSET);
					y = fm;
				end
				HDG_2: begin
					x = sm + int'(SIDE_OFFSET_HDG_2);
					y = fm;
				end
				default: begin
					x = fm;
					y = sm + int'(SIDE_OFFSET);
				end
			endcase
			p.coord_x = x[COORD_W-1:0];
			p.coord_y = y[COORD_W-1:0];
			expected_q.push_back(p);
			front_cnt = 0;
			side_cnt = 0;
		endfunction

		function void check_pos(position_t got);
			position_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected position item x=%0d y=%0d", $time,
					got.coord_x, got.coord_y);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.coord_x !== want.coord_x) begin
				$display("%0t: coord_x mismatch, expected %0d, actual %0d", $time,
					want.coord_x, got.coord_x);
				errors++;
			end
			if (got.coord_y !== want.coord_y) begin
				$display("%0t: coord_y mismatch, expected %0d, actual %0d", $time,
					want.coord_y, got.coord_y);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import hmpf_pkg::*;
	import hmpf_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	// Queue entries, one sort pass per stored sample and the output load, with margin.
	localparam int SETTLE_CYCLES = 4 * (FILL + QUEUE_DEPTH + 2);
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic pos_valid;
	logic pos_stall = 1'b0;
	position_t pos;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_HEADING;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	position_scoreboard board;

	heading_median_position_filter_unit #(
		.SAMPLES(FILL)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.pos_valid(pos_valid),
		.pos_stall(pos_stall),
		.pos(pos),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		pos_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Handshake monitor and watchdog.
	always @(posedge clk) begin
		if (sample_valid && !sample_stall)
			board.note_sample(sample);
		if (pos_valid && !pos_stall)
			board.check_pos(pos);
		if (cfg_valid && cfg_ready)
			board.write_reg(cfg_index, cfg_data);
		if ((sample_valid && !sample_stall) || (pos_valid && !pos_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic sample_t readings(int fl, int fr, int lc, int rc);
		sample_t s;
		s.front_left_cm = CM_W'(fl);
		s.front_right_cm = CM_W'(fr);
		s.left_cm = CM_W'(lc);
		s.right_cm = CM_W'(rc);
		return s;
	endfunction

	// Mostly values that land inside the accepted range, with extremes and full noise.
	function automatic logic [CM_W-1:0] pick_cm();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return CM_W'($urandom);
			default: return CM_W'($urandom_range(500));
		endcase
	endfunction

	task automatic send_sample(sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every expected position item has arrived and the block has settled.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_phase(int ph);
		case (ph)
			0: write_reg(REG_HEADING, CFG_DATA_W'(HDG_1));
			1: begin
				// Upper bits set: only the low two bits select the heading.
				write_reg(REG_HEADING, {{(CFG_DATA_W-2){1'b1}}, HDG_2});
				write_reg(REG_MAX_RANGE, '1);
			end
			2: begin
				write_reg(REG_HEADING, CFG_DATA_W'(HDG_3));
				write_reg(REG_ARENA_LENGTH, '0);
				write_reg(REG_ARENA_WIDTH, '0);
				write_reg(REG_MAX_RANGE, '0);
			end
			3: begin
				write_reg(REG_HEADING, CFG_DATA_W'(HDG_0));
				write_reg(REG_ARENA_LENGTH, '1);
				write_reg(REG_ARENA_WIDTH, '1);
				write_reg(REG_MAX_RANGE, '1);
			end
			default: begin
				write_reg(REG_HEADING, CFG_DATA_W'($urandom));
				if ($urandom_range(1))
					write_reg(REG_ARENA_LENGTH, CFG_DATA_W'($urandom));
				if ($urandom_range(1))
					write_reg(REG_ARENA_WIDTH, CFG_DATA_W'($urandom));
				if ($urandom_range(1))
					write_reg(REG_MAX_RANGE, CFG_DATA_W'($urandom_range(150, 1023)));
			end
		endcase
	endtask

	task automatic run_directed();
		// Front fills first while the side readings are too far.
		send_sample(readings(0, 0, 0, 0));
		send_sample(readings(1023, 1023, 1023, 1023));
		send_sample(readings(234, 500, 450, 0));
		send_sample(readings(600, 235, 451, 5));
		send_sample(readings(247, 247, 9, 1023));
		send_sample(readings(100, 200, 1000, 0));
		send_sample(readings(300, 20, 700, 1));
		send_sample(readings(0, 1023, 512, 2));
		send_sample(readings(5, 6, 1023, 3));
		// Front channel is full now and drops these while the side catches up.
		send_sample(readings(0, 0, 17, 1023));
		send_sample(readings(1023, 1023, 300, 0));
		send_sample(readings(512, 511, 1, 0));
		send_sample(readings(9, 9, 449, 7));
		send_sample(readings(100, 100, 88, 0));
		send_sample(readings(0, 0, 200, 0));
		wait_idle();
		write_reg(REG_HEADING, CFG_DATA_W'(HDG_3));
		send_sample(readings(1023, 1012, 0, 1023));
		send_sample(readings(1011, 1023, 450, 1023));
		send_sample(readings(0, 0, 451, 0));
	endtask

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 11;
		recv_stall_pct = 71;
		run_directed();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES / 3) begin
				send_idle_pct = 71;
				recv_stall_pct = 11;
			end else if (ph == 2 * PHASES / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			wait_idle();
			configure_phase(ph);
			repeat (PHASE_ITEMS)
				send_sample(readings(pick_cm(), pick_cm(), pick_cm(), pick_cm()));
		end
		wait_idle();

		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/hmpf_pkg.sv
sv/hmpf_front.sv
sv/hmpf_queue.sv
sv/hmpf_back.sv
sv/heading_median_position_filter_unit.sv
bench/hmpf_tb_pkg.sv
bench/tb_top.sv
